/* sv/tcoa_pkg.sv */
// ----------------------------------------------------------------------------
// tcoa_pkg
// Shared codes for the transmit channel ownership arbiter: transaction kinds,
// result codes, the width of the idle tick counter and result field positions.
// ----------------------------------------------------------------------------
package tcoa_pkg;

  // Kind of an input transaction, carried on s_tuser.
  typedef enum logic [1:0] {
    FUNC_SUBMIT  = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  // Outcome reported in the result_code field.
  typedef enum logic [1:0] {
    RES_ACCEPTED   = 2'd0,
    RES_REJECTED   = 2'd1,
    RES_DECLINED   = 2'd2,
    RES_NOT_SUBMIT = 2'd3
  } result_code_t;

  localparam int unsigned IDLE_W = 16;

  // Bit positions of the fixed fields in a result transaction.
  localparam int unsigned OUT_CODE_LSB      = 0;
  localparam int unsigned OUT_WRITE_AUDIO   = 2;
  localparam int unsigned OUT_CLEAR_BUFFER  = 3;
  localparam int unsigned OUT_GRANTED       = 4;
  localparam int unsigned OUT_PREEMPTED     = 5;
  localparam int unsigned OUT_RELEASED      = 6;
  localparam int unsigned OUT_CONFLICT      = 7;
  localparam int unsigned OUT_OWNER_CHANGED = 8;
  localparam int unsigned OUT_OWNER_VALID   = 9;
  localparam int unsigned OUT_ID_LSB        = 10;

endpackage

/* sv/tx_channel_ownership_arbiter.sv */
// ----------------------------------------------------------------------------
// tx_channel_ownership_arbiter
// Decides which client owns the shared transmit channel, one transaction per
// cycle while not stalled, with a registered result and an output skid stage.
// ----------------------------------------------------------------------------
// Usage
//   Input transactions arrive on the s_ stream: s_tuser carries the kind
//   (submit, release or tick) and s_tdata the client fields. Every accepted
//   input transaction produces exactly one result transaction on the m_
//   stream, in order.
//   The ownership decision is a small compare-and-update on a handful of
//   registers, done in the cycle the input is accepted. The result is then
//   registered, and the sustained throughput is one transaction per cycle
//   as long as the receiver does not stall.
//   When the receiver stalls, one further result is held in a skid register;
//   s_tready falls only while that skid register is occupied, and the block
//   recovers full rate as soon as m_tready returns.
//   The idle timeout is written through cfg_wen/cfg_wdata, by the user only
//   while the block is idle, which the block does not enforce; it takes
//   effect on the next tick. Reset (rst, synchronous) frees the channel,
//   clears the idle count, restores the timeout to 500 ticks and empties the output stages.
// ----------------------------------------------------------------------------
module tx_channel_ownership_arbiter
  import tcoa_pkg::*;
#(
  parameter int unsigned CLIENT_ID_BITS = 8,
  parameter int unsigned PRIORITY_BITS  = 2
) (
  input  logic clk,
  input  logic rst,
  // Configuration: idle_timeout_ticks
  input  logic              cfg_wen,
  input  logic [IDLE_W-1:0] cfg_wdata,
  // Input stream
  input  logic s_tvalid,
  output logic s_tready,
  // tuser: func
  input  logic [1:0] s_tuser,
  // tdata: client_id, client_known, requester_priority, recovered, zero pad
  input  logic [((CLIENT_ID_BITS+PRIORITY_BITS+2+7)/8)*8-1:0] s_tdata,
  // Output stream
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: result_code, write_audio, clear_buffer, granted, preempted,
  // released, conflict, owner_changed, owner_valid, owner_id, other_id,
  // zero pad
  output logic [((2*CLIENT_ID_BITS+10+7)/8)*8-1:0] m_tdata
);

  localparam int unsigned IW      = CLIENT_ID_BITS;
  localparam int unsigned PW      = PRIORITY_BITS;
  localparam int unsigned OUT_W   = 2 * IW + 10;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = {IDLE_W{1'b1}};
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = IDLE_W'(500);

  // Architectural state.
  logic              owned, owned_next;
  logic [IW-1:0]     owner_client, owner_client_next;
  logic [PW-1:0]     owner_priority, owner_priority_next;
  logic [IDLE_W-1:0] idle_ticks, idle_ticks_next;
  logic [IDLE_W-1:0] idle_timeout;

  // Output register and skid register.
  logic              skid_valid;
  logic [OUT_TW-1:0] skid_data;

  // Unpacked input fields.
  func_t         func;
  logic [IW-1:0] client_id;
  logic          client_known;
  logic [PW-1:0] req_pri;
  logic          recovered;

  // Decision outputs.
  result_code_t  code;
  logic          wr, clr, gr, pre, rel, conf, chg;
  logic [IW-1:0] other;
  logic [IDLE_W-1:0] ticks_inc;
  logic [OUT_TW-1:0] result;
  logic              accept_in;
  logic              out_free;

  assign func         = func_t'(s_tuser);
  assign client_id    = s_tdata[IW-1:0];
  assign client_known = s_tdata[IW];
  assign req_pri      = s_tdata[IW+PW:IW+1];
  assign recovered    = s_tdata[IW+PW+1];

  assign s_tready  = !skid_valid;
  assign accept_in = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign ticks_inc = (idle_ticks < IDLE_MAX) ? idle_ticks + 1'b1 : idle_ticks;

  // Ownership decision for the transaction on the input.
  always_comb begin
    owned_next          = owned;
    owner_client_next   = owner_client;
    owner_priority_next = owner_priority;
    idle_ticks_next     = idle_ticks;
    code  = RES_NOT_SUBMIT;
    other = '0;
    wr    = 1'b0;
    clr   = 1'b0;
    gr    = 1'b0;
    pre   = 1'b0;
    rel   = 1'b0;
    conf  = 1'b0;
    chg   = 1'b0;
    case (func)
      FUNC_SUBMIT: begin
        if (!client_known) begin
          // Unregistered sender: refused without touching the channel.
          code = recovered ? RES_DECLINED : RES_REJECTED;
        end else if (!owned) begin
          if (recovered) begin
            code = RES_DECLINED;
          end else begin
            owned_next          = 1'b1;
            owner_client_next   = client_id;
            owner_priority_next = req_pri;
            idle_ticks_next     = '0;
            code = RES_ACCEPTED;
            wr   = 1'b1;
            clr  = 1'b1;
            gr   = 1'b1;
            chg  = 1'b1;
          end
        end else if (owner_client == client_id) begin
          // The owner keeps writing; only live frames refresh the lease.
          if (!recovered) begin
            idle_ticks_next = '0;
          end
          code = RES_ACCEPTED;
          wr   = 1'b1;
        end else if (req_pri > owner_priority) begin
          if (recovered) begin
            code = RES_DECLINED;
          end else begin
            other               = owner_client;
            owner_client_next   = client_id;
            owner_priority_next = req_pri;
            idle_ticks_next     = '0;
            code = RES_ACCEPTED;
            wr   = 1'b1;
            clr  = 1'b1;
            gr   = 1'b1;
            pre  = 1'b1;
            chg  = 1'b1;
          end
        end else begin
          if (recovered) begin
            code = RES_DECLINED;
          end else begin
            other = owner_client;
            code  = RES_REJECTED;
            conf  = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (owned && owner_client == client_id) begin
          other               = owner_client;
          owned_next          = 1'b0;
          owner_client_next   = '0;
          owner_priority_next = '0;
          clr = 1'b1;
          rel = 1'b1;
          chg = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (owned) begin
          idle_ticks_next = ticks_inc;
          if (ticks_inc >= idle_timeout) begin
            other               = owner_client;
            owned_next          = 1'b0;
            owner_client_next   = '0;
            owner_priority_next = '0;
            clr = 1'b1;
            rel = 1'b1;
            chg = 1'b1;
          end
        end
      end
      default: begin
        // Unused kind: no change, owner fields still reported.
      end
    endcase

    result = '0;
    result[OUT_CODE_LSB +: 2]   = code;
    result[OUT_WRITE_AUDIO]     = wr;
    result[OUT_CLEAR_BUFFER]    = clr;
    result[OUT_GRANTED]         = gr;
    result[OUT_PREEMPTED]       = pre;
    result[OUT_RELEASED]        = rel;
    result[OUT_CONFLICT]        = conf;
    result[OUT_OWNER_CHANGED]   = chg;
    result[OUT_OWNER_VALID]     = owned_next;
    result[OUT_ID_LSB +: IW]    = owned_next ? owner_client_next : '0;
    result[OUT_ID_LSB + IW +: IW] = other;
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      owned          <= 1'b0;
      owner_client   <= '0;
      owner_priority <= '0;
      idle_ticks     <= '0;
      idle_timeout   <= TIMEOUT_RESET;
    end else begin
      if (cfg_wen) begin
        idle_timeout <= cfg_wdata;
      end
      if (accept_in) begin
        owned          <= owned_next;
        owner_client   <= owner_client_next;
        owner_priority <= owner_priority_next;
        idle_ticks     <= idle_ticks_next;
      end
    end
  end

  // Output and skid valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept_in) begin
        m_tdata <= result;
      end
    end else if (accept_in) begin
      skid_data <= result;
    end
  end

endmodule

/* sv/tcoa_checker.sv */
// ----------------------------------------------------------------------------
// tcoa_checker
// Port-level checks for the transmit channel ownership arbiter.
// ----------------------------------------------------------------------------
module tcoa_checker
  import tcoa_pkg::*;
#(
  parameter int unsigned CLIENT_ID_BITS = 8,
  parameter int unsigned PRIORITY_BITS  = 2
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*CLIENT_ID_BITS+10+7)/8)*8-1:0] m_tdata
);

  localparam int unsigned IW = CLIENT_ID_BITS;

  logic [1:0]    code;
  logic [IW-1:0] owner_id;

  assign code     = m_tdata[OUT_CODE_LSB +: 2];
  assign owner_id = m_tdata[OUT_ID_LSB +: IW];

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // An unowned channel reports owner 0.
  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_OWNER_VALID] |-> owner_id == '0)
    else $error("owner id shown while channel free");

  // A grant is an accepted claim that leaves the channel owned.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_GRANTED] |->
      code == RES_ACCEPTED && m_tdata[OUT_OWNER_VALID] &&
      m_tdata[OUT_CLEAR_BUFFER] && m_tdata[OUT_OWNER_CHANGED])
    else $error("inconsistent grant");

  // A conflict is a rejection that changes nothing.
  a_conflict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_CONFLICT] |->
      code == RES_REJECTED && !m_tdata[OUT_OWNER_CHANGED] &&
      !m_tdata[OUT_WRITE_AUDIO])
    else $error("inconsistent conflict");

  // After reset the output is empty and the input is open.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

endmodule

bind tx_channel_ownership_arbiter tcoa_checker #(
  .CLIENT_ID_BITS(CLIENT_ID_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_tcoa_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* sim/tx_channel_ownership_arbiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_channel_ownership_arbiter_tb
// Self-checking bench for the transmit channel ownership arbiter. A short
// table of hand-written transactions is followed by several phases of random
// traffic under different idle timeouts. Every result transaction is compared
// field by field with a typed-in result or the bench's behavioural arbiter.
// ----------------------------------------------------------------------------
module tx_channel_ownership_arbiter_tb;
  import tcoa_pkg::*;

  localparam int unsigned ID_BITS          = 8;
  localparam int unsigned PRI_BITS         = 2;
  localparam int unsigned S_W              = ((ID_BITS + PRI_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned M_W              = ((2 * ID_BITS + 10 + 7) / 8) * 8;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned MAX_GAP          = 4;
  // Cycles allowed after the last result before a register write or the end.
  localparam int unsigned DRAIN_CYCLES     = 4;
  // The slowest correct stretch without a handshake is made up of sender
  // gap, receiver stall and drain; this limit is far above that.
  localparam int unsigned WATCHDOG_CYCLES  = 2000;
  localparam int unsigned N_PHASES         = 9;
  localparam int unsigned ITEMS_PER_PHASE  = 200;
  localparam logic [IDLE_W-1:0] TIMEOUT_AT_RESET = 16'd500;
  localparam logic [IDLE_W-1:0] TIMEOUT_MAX      = '1;

  // One input transaction, field by field.
  typedef struct packed {
    func_t               func;
    logic [ID_BITS-1:0]  client;
    logic                known;
    logic [PRI_BITS-1:0] pri;
    logic                rec;
  } request_t;

  // One result transaction. The eight flags sit together so that directed
  // rows can give them as one 8-bit literal in this order.
  typedef struct packed {
    result_code_t       code;
    logic               write_audio;
    logic               clear_buffer;
    logic               granted;
    logic               preempted;
    logic               released;
    logic               conflict;
    logic               owner_changed;
    logic               owner_valid;
    logic [ID_BITS-1:0] owner_id;
    logic [ID_BITS-1:0] other_id;
  } verdict_t;

  // A row of the directed table: either a timeout write, or a transaction
  // whose result is typed in (fixed) or left to the arbiter model.
  typedef struct {
    bit                cfg_write;
    logic [IDLE_W-1:0] cfg_val;
    request_t          req;
    bit                fixed;
    verdict_t          want;
  } stim_row_t;

  // DUT ports. Every input has a known value from time zero.
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_wen   = 1'b0;
  logic [IDLE_W-1:0] cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [1:0]        s_tuser   = '0;  // func
  // client_id, client_known, requester_priority, recovered, zero pad
  logic [S_W-1:0]    s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  // result_code, write_audio, clear_buffer, granted, preempted, released,
  // conflict, owner_changed, owner_valid, owner_id, other_id, zero pad
  logic [M_W-1:0]    m_tdata;

  // Shadow of the arbiter state and its one register.
  logic                chan_owned;
  logic [ID_BITS-1:0]  chan_owner;
  logic [PRI_BITS-1:0] chan_pri;
  logic [IDLE_W-1:0]   idle_count;
  logic [IDLE_W-1:0]   timeout_ticks;

  // Results still owed by the DUT, oldest first.
  verdict_t pending_verdicts[$];

  // The directed table, walked in order.
  stim_row_t stim_table[$];

  // When set, neither side inserts gaps, giving stretches at full rate.
  bit back_to_back = 1'b0;

  logic [ID_BITS-1:0] frequent_ids[4];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int claims = 0;
  int preemptions = 0;
  int conflicts = 0;
  int timeouts = 0;
  int timeout_settings = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  tx_channel_ownership_arbiter #(
    .CLIENT_ID_BITS(ID_BITS),
    .PRIORITY_BITS (PRI_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Arbiter model
  // --------------------------------------------------------------------------

  function automatic void seize(request_t r);
    chan_owned = 1'b1;
    chan_owner = r.client;
    chan_pri   = r.pri;
    idle_count = '0;
  endfunction

  // Releasing the channel clears the owner fields but leaves the idle count;
  // the next claim zeroes it anyway.
  function automatic void vacate();
    chan_owned = 1'b0;
    chan_owner = '0;
    chan_pri   = '0;
  endfunction

  // Applies one transaction to the shadow state and returns the result the
  // DUT should produce for it.
  function automatic verdict_t arbitrate(request_t r);
    verdict_t v;
    v = '0;
    v.code = RES_NOT_SUBMIT;
    case (r.func)
      FUNC_SUBMIT: begin
        if (!r.known) begin
          // Unregistered senders never touch the channel, and a live frame
          // from one is rejected without being counted as a conflict.
          v.code = r.rec ? RES_DECLINED : RES_REJECTED;
        end else if (chan_owner == r.client && chan_owned) begin
          // The owner may always write; only live audio renews the lease.
          if (!r.rec) begin
            idle_count = '0;
          end
          v.code = RES_ACCEPTED;
          v.write_audio = 1'b1;
        end else if (r.rec) begin
          // Recovered frames never claim, preempt or raise a conflict.
          v.code = RES_DECLINED;
        end else if (!chan_owned || r.pri > chan_pri) begin
          if (chan_owned) begin
            v.other_id = chan_owner;
            v.preempted = 1'b1;
            preemptions++;
          end else begin
            claims++;
          end
          seize(r);
          v.code = RES_ACCEPTED;
          v.write_audio = 1'b1;
          v.clear_buffer = 1'b1;
          v.granted = 1'b1;
          v.owner_changed = 1'b1;
        end else begin
          v.other_id = chan_owner;
          v.code = RES_REJECTED;
          v.conflict = 1'b1;
          conflicts++;
        end
      end
      FUNC_RELEASE: begin
        // A release is honoured whether or not the client is still registered.
        if (chan_owned && chan_owner == r.client) begin
          v.other_id = chan_owner;
          vacate();
          v.clear_buffer = 1'b1;
          v.released = 1'b1;
          v.owner_changed = 1'b1;
        end
      end
      FUNC_TICK: begin
        // The idle count saturates, then the timeout is compared against
        // the updated count.
        if (chan_owned) begin
          if (idle_count != TIMEOUT_MAX) begin
            idle_count = idle_count + 1'b1;
          end
          if (idle_count >= timeout_ticks) begin
            v.other_id = chan_owner;
            vacate();
            v.clear_buffer = 1'b1;
            v.released = 1'b1;
            v.owner_changed = 1'b1;
            timeouts++;
          end
        end
      end
      default: begin
      end
    endcase
    v.owner_valid = chan_owned;
    v.owner_id = chan_owned ? chan_owner : '0;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------

  function automatic request_t make_req(func_t f, logic [ID_BITS-1:0] id, bit known,
                                        logic [PRI_BITS-1:0] pri, bit rec);
    request_t r;
    r.func = f;
    r.client = id;
    r.known = known;
    r.pri = pri;
    r.rec = rec;
    return r;
  endfunction

  // flags: write_audio, clear_buffer, granted, preempted, released, conflict,
  // owner_changed, owner_valid, from the top bit down.
  function automatic verdict_t outcome(result_code_t code, logic [7:0] flags,
                                       logic [ID_BITS-1:0] owner,
                                       logic [ID_BITS-1:0] other);
    return verdict_t'({code, flags, owner, other});
  endfunction

  function automatic stim_row_t checked_row(request_t r, verdict_t want);
    stim_row_t row;
    row.cfg_write = 1'b0;
    row.cfg_val = '0;
    row.req = r;
    row.fixed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t predicted_row(request_t r);
    stim_row_t row;
    row = checked_row(r, '0);
    row.fixed = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t timeout_row(logic [IDLE_W-1:0] ticks);
    stim_row_t row;
    row = predicted_row('0);
    row.cfg_write = 1'b1;
    row.cfg_val = ticks;
    return row;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void add_row(stim_row_t row);
    stim_table.insert(stim_table.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Presents one transaction and returns just after the edge at which it was
  // accepted. tvalid is left high so that a following transaction with no
  // gap goes out on the very next cycle; it is only lowered when a gap is
  // drawn, which is always at a later time step than the raise.
  task automatic push_request(request_t r, bit fixed, verdict_t want);
    int gap;
    verdict_t model_out;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.func;
    s_tdata  <= {{(S_W - ID_BITS - PRI_BITS - 2){1'b0}}, r.rec, r.pri, r.known, r.client};
    do @(posedge clk); while (!s_tready);
    // The model is advanced for every row, so that typed-in rows keep the
    // shadow state in step as well.
    model_out = arbitrate(r);
    pending_verdicts.insert(pending_verdicts.size(), fixed ? want : model_out);
    items_sent++;
  endtask

  // Writes the idle timeout once the block has gone quiet: the input side is
  // closed, every owed result has been collected, and the output stages have
  // then been left to drain.
  task automatic set_timeout(logic [IDLE_W-1:0] ticks);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_wen <= 1'b0;
    timeout_ticks = ticks;
    timeout_settings++;
  endtask

  // Random traffic is biased towards a few recurring clients and the current
  // owner, so that renewals, conflicts, preemptions and releases by the owner
  // all happen often. The rest is noise: arbitrary ids, unknown clients and
  // the unused kind.
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.func = FUNC_SUBMIT;
    end else if (pick < 65) begin
      r.func = FUNC_RELEASE;
    end else if (pick < 97) begin
      r.func = FUNC_TICK;
    end else begin
      r.func = FUNC_UNUSED;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.client = frequent_ids[$urandom_range(0, 3)];
    end else if (pick < 80) begin
      r.client = chan_owner;
    end else begin
      r.client = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    end
    r.known = ($urandom_range(0, 9) != 0);
    r.pri = PRI_BITS'($urandom_range(0, (1 << PRI_BITS) - 1));
    r.rec = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  initial begin : stimulus
    logic [IDLE_W-1:0] phase_timeout;

    // Directed table. Rows with a typed-in result cover the cases that can be
    // read straight off the rules; the timing of the lease is left to the
    // model. The timeout is 500 after reset.
    //                      func          id     kn pri rec
    // --- nothing owned yet
    add_row(checked_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0000_0000, 8'h00, 8'h00)));
    add_row(checked_row(make_req(FUNC_RELEASE, 8'hFF, 1, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0000_0000, 8'h00, 8'h00)));
    // Unknown clients: live rejected without conflict, recovered declined.
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hFF, 0, 3, 0),
        outcome(RES_REJECTED,   8'b0000_0000, 8'h00, 8'h00)));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hFF, 0, 3, 1),
        outcome(RES_DECLINED,   8'b0000_0000, 8'h00, 8'h00)));
    // A recovered frame cannot claim a free channel.
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'h12, 1, 3, 1),
        outcome(RES_DECLINED,   8'b0000_0000, 8'h00, 8'h00)));
    // --- claim at the lowest priority, then owner traffic
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hFF, 1, 0, 0),
        outcome(RES_ACCEPTED,   8'b1110_0011, 8'hFF, 8'h00)));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hFF, 1, 0, 1),
        outcome(RES_ACCEPTED,   8'b1000_0001, 8'hFF, 8'h00)));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hFF, 1, 3, 0),
        outcome(RES_ACCEPTED,   8'b1000_0001, 8'hFF, 8'h00)));
    // Equal priority does not preempt; a recovered frame never does.
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'h00, 1, 0, 0),
        outcome(RES_REJECTED,   8'b0000_0101, 8'hFF, 8'hFF)));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'h01, 1, 3, 1),
        outcome(RES_DECLINED,   8'b0000_0001, 8'hFF, 8'h00)));
    // Strictly higher priority preempts; the new owner has id zero.
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'h00, 1, 1, 0),
        outcome(RES_ACCEPTED,   8'b1111_0011, 8'h00, 8'hFF)));
    add_row(checked_row(make_req(FUNC_UNUSED,  8'h00, 1, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0000_0001, 8'h00, 8'h00)));
    // Release by a non-owner is ignored; the owner may release unregistered.
    add_row(checked_row(make_req(FUNC_RELEASE, 8'hFF, 1, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0000_0001, 8'h00, 8'h00)));
    add_row(checked_row(make_req(FUNC_RELEASE, 8'h00, 0, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0100_1010, 8'h00, 8'h00)));
    // --- shortest timeout: the first tick releases
    add_row(timeout_row(16'd1));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'hA5, 1, 3, 0),
        outcome(RES_ACCEPTED,   8'b1110_0011, 8'hA5, 8'h00)));
    add_row(checked_row(make_req(FUNC_SUBMIT,  8'h5A, 1, 3, 0),
        outcome(RES_REJECTED,   8'b0000_0101, 8'hA5, 8'hA5)));
    add_row(checked_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0),
        outcome(RES_NOT_SUBMIT, 8'b0100_1010, 8'h00, 8'hA5)));
    // --- lease renewal: live owner audio restarts the count, recovered not
    add_row(timeout_row(16'd3));
    add_row(predicted_row(make_req(FUNC_SUBMIT,  8'h3C, 1, 2, 0)));
    add_row(predicted_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0)));
    add_row(predicted_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0)));
    add_row(predicted_row(make_req(FUNC_SUBMIT,  8'h3C, 1, 2, 0)));
    add_row(predicted_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0)));
    add_row(predicted_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0)));
    add_row(predicted_row(make_req(FUNC_SUBMIT,  8'h3C, 1, 2, 1)));
    add_row(predicted_row(make_req(FUNC_TICK,    8'h00, 1, 0, 0)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    chan_owned = 1'b0;
    chan_owner = '0;
    chan_pri = '0;
    idle_count = '0;
    timeout_ticks = TIMEOUT_AT_RESET;

    foreach (stim_table[i]) begin
      if (stim_table[i].cfg_write) begin
        set_timeout(stim_table[i].cfg_val);
      end else begin
        push_request(stim_table[i].req, stim_table[i].fixed, stim_table[i].want);
      end
    end

    // Random phases. The first two use the extreme timeouts, one a large
    // value, the rest small values so that ticks release owners often.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: phase_timeout = 16'd1;
        1: phase_timeout = TIMEOUT_MAX;
        2: phase_timeout = IDLE_W'($urandom_range(1000, 65534));
        default: phase_timeout = IDLE_W'($urandom_range(2, 12));
      endcase
      set_timeout(phase_timeout);
      foreach (frequent_ids[i]) begin
        frequent_ids[i] = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          back_to_back = ($urandom_range(0, 3) == 0);
        end
        push_request(random_request(), 1'b0, '0);
      end
      back_to_back = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions under %0d timeout settings; %0d results checked.",
             items_sent, timeout_settings, results_seen);
    $display("Seen: %0d claims, %0d preemptions, %0d conflicts, %0d idle timeouts.",
             claims, preemptions, conflicts, timeouts);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Draws a stall before each result, then collects the result at the edge
  // where tvalid and tready are both high and checks it against the oldest
  // owed verdict.
  initial begin : result_sink
    int stall;
    verdict_t want;
    verdict_t got;
    do @(posedge clk); while (rst);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      got.code          = result_code_t'(m_tdata[OUT_CODE_LSB +: 2]);
      got.write_audio   = m_tdata[OUT_WRITE_AUDIO];
      got.clear_buffer  = m_tdata[OUT_CLEAR_BUFFER];
      got.granted       = m_tdata[OUT_GRANTED];
      got.preempted     = m_tdata[OUT_PREEMPTED];
      got.released      = m_tdata[OUT_RELEASED];
      got.conflict      = m_tdata[OUT_CONFLICT];
      got.owner_changed = m_tdata[OUT_OWNER_CHANGED];
      got.owner_valid   = m_tdata[OUT_OWNER_VALID];
      got.owner_id      = m_tdata[OUT_ID_LSB +: ID_BITS];
      got.other_id      = m_tdata[OUT_ID_LSB + ID_BITS +: ID_BITS];
      if (pending_verdicts.size() == 0) begin
        $error("Result transaction arrived with none outstanding");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("result_code",   want.code,          got.code);
        check_field("write_audio",   want.write_audio,   got.write_audio);
        check_field("clear_buffer",  want.clear_buffer,  got.clear_buffer);
        check_field("granted",       want.granted,       got.granted);
        check_field("preempted",     want.preempted,     got.preempted);
        check_field("released",      want.released,      got.released);
        check_field("conflict",      want.conflict,      got.conflict);
        check_field("owner_changed", want.owner_changed, got.owner_changed);
        check_field("owner_valid",   want.owner_valid,   got.owner_valid);
        check_field("owner_id",      want.owner_id,      got.owner_id);
        check_field("other_id",      want.other_id,      got.other_id);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no handshake on
  // either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
